>>> rtl/bfsca_pkg.sv
package bfsca_pkg;

  localparam int unsigned ALIGN_BYTES_DEF   = 16;
  localparam int unsigned HEAP_GRANULES_DEF = 4096;
  localparam logic [31:0] HDR_BYTES         = 32'd4;
  localparam logic [31:0] HEAP_LIMIT_RST    = 32'd65536;
  localparam logic [32:0] SIZE_LIMIT        = 33'h0_8000_0000;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic REG_HEAP_BASE  = 1'b0;
  localparam logic REG_HEAP_LIMIT = 1'b1;

  typedef struct packed {
    logic        action;
    logic [31:0] request_bytes;
    logic [31:0] address;
  } bfsca_in_t;

  typedef struct packed {
    logic [31:0] result_address;
    logic        ok;
  } bfsca_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLR,
    ST_SCAN,
    ST_HEAD_WT,
    ST_NEXT_WT,
    ST_POP_WT,
    ST_BUMP,
    ST_FREE_RD,
    ST_FREE_WT,
    ST_FREE_NE,
    ST_FREE_HWT,
    ST_FREE_LINK,
    ST_DONE
  } bfsca_state_t;

endpackage

>>> rtl/bfsca_front.sv
module bfsca_front #(
  parameter int unsigned ALIGN_BYTES = bfsca_pkg::ALIGN_BYTES_DEF,
  parameter int unsigned GW          = 12
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  bfsca_pkg::bfsca_in_t in_data,
  input  logic [31:0]          heap_base,
  output logic                 q_valid,
  input  logic                 q_ready,
  output logic                 q_action,
  output logic                 q_bad,
  output logic [32:0]          q_size,
  output logic [GW:0]          q_gran,
  output logic [31:0]          q_off
);
  import bfsca_pkg::*;

  localparam int unsigned AB = $clog2(ALIGN_BYTES);

  logic        v_r;
  logic        act_r, bad_r;
  logic [32:0] size_r;
  logic [GW:0] gran_r;
  logic [31:0] off_r;
  logic [32:0] sum;
  logic [32:0] rnd;
  logic [31:0] chunk;
  logic [32:0] g_full;

  assign in_ready = !v_r || q_ready;
  assign sum      = {1'b0, in_data.request_bytes} + {1'b0, HDR_BYTES}
                    + 33'(ALIGN_BYTES - 1);
  assign rnd      = (sum >> AB) << AB;
  assign g_full   = rnd >> AB;
  assign chunk    = in_data.address - HDR_BYTES;

  // A granule count too wide for its GW+1 bit field saturates to all ones, which no
  // class and no bump allocation can hold.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      act_r  <= in_data.action;
      size_r <= rnd;
      gran_r <= (g_full[32:GW+1] != '0) ? {(GW+1){1'b1}} : g_full[GW:0];
      off_r  <= chunk - heap_base;
      if (in_data.action == ACT_ALLOC) begin
        bad_r <= (rnd >= SIZE_LIMIT);
      end else begin
        bad_r <= (in_data.address < HDR_BYTES) || (chunk < heap_base);
      end
    end
  end

  assign q_valid  = v_r;
  assign q_action = act_r;
  assign q_bad    = bad_r;
  assign q_size   = size_r;
  assign q_gran   = gran_r;
  assign q_off    = off_r;
endmodule

>>> rtl/bfsca_back.sv
module bfsca_back #(
  parameter int unsigned ALIGN_BYTES   = bfsca_pkg::ALIGN_BYTES_DEF,
  parameter int unsigned HEAP_GRANULES = bfsca_pkg::HEAP_GRANULES_DEF,
  parameter int unsigned GW            = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  output logic                  q_ready,
  input  logic                  q_action,
  input  logic                  q_bad,
  input  logic [32:0]           q_size,
  input  logic [GW:0]           q_gran,
  input  logic [31:0]           q_off,
  input  logic [31:0]           heap_base,
  input  logic [31:0]           heap_limit,
  input  logic                  base_wr,
  output logic                  out_valid,
  input  logic                  out_ready,
  output bfsca_pkg::bfsca_out_t out_data
);
  import bfsca_pkg::*;

  localparam int unsigned AB = $clog2(ALIGN_BYTES);
  localparam int unsigned NG = HEAP_GRANULES;

  bfsca_state_t st_r, st_nxt;

  logic          ne_mem   [NG];
  logic [GW-1:0] head_mem [NG];
  logic [GW:0]   next_mem [NG];
  logic [GW:0]   gran_mem [NG];

  logic          ne_q;
  logic [GW-1:0] head_q;
  logic [GW:0]   next_q, gran_q;
  logic [GW-1:0] ne_ra, head_ra, next_ra, gran_ra;

  logic          ne_we, head_we, next_we, gran_we;
  logic [GW-1:0] ne_wa, head_wa, next_wa, gran_wa;
  logic          ne_wd;
  logic [GW-1:0] head_wd;
  logic [GW:0]   next_wd, gran_wd;

  logic [GW-1:0] clr_r;
  logic [31:0]   bump_r;
  logic [GW:0]   cls_r;
  logic [GW-1:0] h_r, g_r;
  logic [GW-1:0] nx_r;
  logic [32:0]   size_r;
  logic [GW:0]   gran_r;
  logic [31:0]   off_r;
  bfsca_out_t    res_r, res_hold_r;
  logic          ov_r;

  logic          bump_upd;
  logic          res_ld;
  logic          out_ld;
  bfsca_out_t    res_nxt;
  logic [31:0]   boff;
  logic [32:0]   bend;
  logic [GW-1:0] fcls;

  always_ff @(posedge clk) begin
    if (ne_we) ne_mem[ne_wa] <= ne_wd;
    if (head_we) head_mem[head_wa] <= head_wd;
    if (next_we) next_mem[next_wa] <= next_wd;
    if (gran_we) gran_mem[gran_wa] <= gran_wd;
    ne_q   <= ne_mem[ne_ra];
    head_q <= head_mem[head_ra];
    next_q <= next_mem[next_ra];
    gran_q <= gran_mem[gran_ra];
  end

  assign boff = bump_r - heap_base;
  assign bend = {1'b0, bump_r} + size_r;
  assign fcls = GW'(gran_q - 1'b1);

  assign q_ready   = (st_r == ST_IDLE);
  assign out_valid = ov_r;
  assign out_data  = res_r;

  always_comb begin
    st_nxt   = st_r;
    ne_we    = 1'b0; head_we = 1'b0; next_we = 1'b0; gran_we = 1'b0;
    ne_wa    = cls_r[GW-1:0]; ne_wd = 1'b0;
    head_wa  = cls_r[GW-1:0]; head_wd = g_r;
    next_wa  = g_r; next_wd = '0;
    gran_wa  = boff[AB+GW-1:AB]; gran_wd = gran_r;
    ne_ra    = cls_r[GW-1:0];
    head_ra  = cls_r[GW-1:0];
    next_ra  = h_r;
    gran_ra  = off_r[AB+GW-1:AB];
    bump_upd = 1'b0;
    res_ld   = 1'b0;
    out_ld   = 1'b0;
    res_nxt  = '0;
    unique case (st_r)
      ST_CLR: begin
        ne_we = 1'b1; ne_wa = clr_r; ne_wd = 1'b0;
        if (clr_r == GW'(NG - 1)) st_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        ne_ra = GW'(q_gran - 1'b1);
        if (q_valid) begin
          if (q_bad) begin
            st_nxt = ST_DONE;
            res_ld = 1'b1;
          end else if (q_action == ACT_FREE) begin
            st_nxt = ST_FREE_RD;
          end else if (q_gran >= 1 && q_gran <= (GW+1)'(NG)) begin
            st_nxt = ST_SCAN;
          end else begin
            st_nxt = ST_BUMP;
          end
        end
      end
      ST_SCAN: begin
        if (cls_r >= (GW+1)'(NG)) begin
          st_nxt = ST_BUMP;
        end else if (ne_q) begin
          st_nxt = ST_HEAD_WT;
        end else begin
          ne_ra = GW'(cls_r + 1'b1);
        end
      end
      ST_HEAD_WT: begin
        next_ra = head_q;
        st_nxt  = ST_NEXT_WT;
      end
      ST_NEXT_WT: begin
        if (next_q[GW]) begin
          next_ra = next_q[GW-1:0];
          st_nxt  = ST_POP_WT;
        end else begin
          ne_we   = 1'b1;
          res_ld  = 1'b1;
          res_nxt.result_address = heap_base + (32'(h_r) << AB) + HDR_BYTES;
          res_nxt.ok = 1'b1;
          st_nxt  = ST_DONE;
        end
      end
      ST_POP_WT: begin
        next_we = 1'b1; next_wa = h_r; next_wd = next_q;
        res_ld  = 1'b1;
        res_nxt.result_address = heap_base + (32'(nx_r) << AB) + HDR_BYTES;
        res_nxt.ok = 1'b1;
        st_nxt  = ST_DONE;
      end
      ST_BUMP: begin
        res_ld = 1'b1;
        st_nxt = ST_DONE;
        if (bend < {1'b0, heap_limit} && bump_r >= heap_base && boff[AB-1:0] == '0
            && ({1'b0, boff} >> AB) + 33'(gran_r) <= 33'(NG)) begin
          gran_we  = 1'b1;
          bump_upd = 1'b1;
          res_nxt.result_address = bump_r + HDR_BYTES;
          res_nxt.ok = 1'b1;
        end
      end
      ST_FREE_RD: begin
        if (off_r[AB-1:0] != '0 || (off_r >> AB) >= 32'(NG)) begin
          res_ld = 1'b1;
          st_nxt = ST_DONE;
        end else begin
          st_nxt = ST_FREE_WT;
        end
      end
      ST_FREE_WT: begin
        if (gran_q != '0 && gran_q <= (GW+1)'(NG)) begin
          ne_ra   = fcls;
          head_ra = fcls;
          st_nxt  = ST_FREE_NE;
        end else begin
          res_ld = 1'b1;
          st_nxt = ST_DONE;
        end
      end
      ST_FREE_NE: begin
        if (!ne_q) begin
          ne_we   = 1'b1; ne_wd = 1'b1;
          head_we = 1'b1;
          next_we = 1'b1; next_wa = g_r; next_wd = '0;
          res_ld  = 1'b1;
          res_nxt.ok = 1'b1;
          st_nxt  = ST_DONE;
        end else begin
          next_ra = head_q;
          st_nxt  = ST_FREE_HWT;
        end
      end
      ST_FREE_HWT: begin
        next_we = 1'b1; next_wa = g_r; next_wd = next_q;
        st_nxt  = ST_FREE_LINK;
      end
      ST_FREE_LINK: begin
        next_we = 1'b1; next_wa = h_r; next_wd = {1'b1, g_r};
        res_ld  = 1'b1;
        res_nxt.ok = 1'b1;
        st_nxt  = ST_DONE;
      end
      ST_DONE: begin
        if (!ov_r || out_ready) begin
          out_ld = 1'b1;
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_CLR;
      clr_r  <= '0;
      ov_r   <= 1'b0;
      bump_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (st_r == ST_CLR) clr_r <= clr_r + 1'b1;
      if (base_wr) bump_r <= heap_base;
      else if (bump_upd) bump_r <= bend[31:0];
      if (out_ld) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
    end
    if (out_ld) res_r <= res_hold_r;
    if (res_ld) res_hold_r <= res_nxt;
    if (st_r == ST_IDLE && q_valid) begin
      cls_r  <= q_gran - 1'b1;
      size_r <= q_size;
      gran_r <= q_gran;
      off_r  <= q_off;
      g_r    <= q_off[AB+GW-1:AB];
    end
    if (st_r == ST_SCAN && !ne_q && cls_r < (GW+1)'(NG)) cls_r <= cls_r + 1'b1;
    if (st_r == ST_FREE_WT) cls_r <= {1'b0, fcls};
    if (st_r == ST_HEAD_WT || st_r == ST_FREE_NE) h_r <= head_q;
    if (st_r == ST_NEXT_WT) nx_r <= next_q[GW-1:0];
  end
endmodule

>>> rtl/best_fit_size_class_allocator_unit.sv
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid/in_ready    | in_data (bfsca_in_t)
// out     | output    | out_valid/out_ready  | out_data (bfsca_out_t)
// cfg     | input     | psel/penable/pwrite  | paddr, pwdata, prdata
// An allocate scans upward from its own class past each empty class and takes a chunk from
// the first nonempty one: the head or, when the head has a successor, the linked chunk.
// An allocate that finds no chunk scans to the last class and falls to the bump pointer;
// one too large for the heap goes to the bump pointer at once, and an oversized request fails.
// A free links into its class, empty or nonempty, and is ignored when its chunk is bad.
// Synchronous reset clears the pointers, then the class map is cleared before the first
// item moves to the back. A stalled result holds in the output register; the back and the
// front then each hold one more item before in_ready falls.
module best_fit_size_class_allocator_unit #(
  parameter int unsigned ALIGN_BYTES   = bfsca_pkg::ALIGN_BYTES_DEF,
  parameter int unsigned HEAP_GRANULES = bfsca_pkg::HEAP_GRANULES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  bfsca_pkg::bfsca_in_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output bfsca_pkg::bfsca_out_t out_data,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [2:0]            cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);
  import bfsca_pkg::*;

  localparam int unsigned GW = $clog2(HEAP_GRANULES);

  logic [31:0] base_r, limit_r;
  logic        base_wr_r;
  logic        wr;
  logic        q_valid, q_ready, q_action, q_bad;
  logic [32:0] q_size;
  logic [GW:0] q_gran;
  logic [31:0] q_off;

  assign cfg_pready = 1'b1;
  assign wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == REG_HEAP_LIMIT) ? limit_r : base_r;

  // The bump pointer reloads from the new base in the cycle after a base write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r    <= '0;
      limit_r   <= HEAP_LIMIT_RST;
      base_wr_r <= 1'b0;
    end else begin
      base_wr_r <= wr && cfg_paddr[1:0] == 2'b00 && cfg_paddr[2] == REG_HEAP_BASE;
      if (wr && cfg_paddr[1:0] == 2'b00) begin
        if (cfg_paddr[2] == REG_HEAP_BASE) base_r <= cfg_pwdata;
        else limit_r <= cfg_pwdata;
      end
    end
  end

  bfsca_front #(.ALIGN_BYTES(ALIGN_BYTES), .GW(GW)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .heap_base(base_r),
    .q_valid, .q_ready, .q_action, .q_bad, .q_size, .q_gran, .q_off
  );

  bfsca_back #(.ALIGN_BYTES(ALIGN_BYTES), .HEAP_GRANULES(HEAP_GRANULES), .GW(GW)) u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_action, .q_bad, .q_size, .q_gran, .q_off,
    .heap_base(base_r), .heap_limit(limit_r),
    .base_wr(base_wr_r),
    .out_valid, .out_ready, .out_data
  );
endmodule

>>> rtl/bfsca_checker.sv
module bfsca_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_valid,
  input logic                  out_ready,
  input bfsca_pkg::bfsca_out_t out_data,
  input logic                  cfg_pready
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("out hold");
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.ok |-> out_data.result_address == 32'd0) else $error("fail addr");
  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_pready) else $error("pready");
endmodule

bind best_fit_size_class_allocator_unit bfsca_checker u_chk (
  .clk, .rst_n, .out_valid, .out_ready, .out_data, .cfg_pready
);
